// ===== sv/pts_pkg.sv =====
// Shared types and constants for the plane traverse solver.
// No dependencies; imported by every module of the block.
package pts_pkg;

    localparam int OUT_W      = 38;
    localparam int GUARD_BITS = 4;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 136;

    localparam logic [31:0] GAIN_Q32     = 32'h9B74EDA8;
    localparam logic [31:0] HALF_TURN    = 32'h80000000;
    localparam logic [31:0] QUARTER_TURN = 32'h40000000;
    localparam logic [20:0] AS_TURN      = 21'd1296000;
    localparam logic [20:0] AS_DEG       = 21'd3600;
    localparam logic [20:0] AS_MIN       = 21'd60;

    // control that rides along the pipeline
    typedef struct packed {
        logic valid;
        logic inv;
        logic zero;
    } ctl_t;

    // atan(2^-i) as a 32-bit phase
    function automatic logic [31:0] atan_phase(input int idx);
        logic [31:0] r;
        case (idx)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2F9;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/plane_traverse_solver.sv =====
// Top level of the plane traverse solver: stream ports, CORDIC cell chain,
// output register with skid. Uses pts_pkg, pts_prep, pts_cell, pts_post.

// Plane traverse solver. Each transfer on the slave side is one problem:
// tuser = 0 is the forward problem (start point, distance, bearing in
// deg/min/sec -> end point), tuser = 1 the inverse problem (two points ->
// distance and bearing in deg/min/sec, 0..359). Results carry FRAC_BITS
// fraction bits; unused fields of each mode read as zero. The block takes one
// transfer per clock while s_tready is high and is fully pipelined: a result
// passes through the three front-end stages, one register per CORDIC cell,
// the three back-end stages and finally the output register. An output
// register backed by a one-entry skid stage keeps s_tready high while a
// finished result waits; s_tready drops only once the skid entry is
// occupied, and the whole pipe then holds until m_tready takes a result.
module plane_traverse_solver #(
    parameter int COORD_BITS    = 21,
    parameter int FRAC_BITS     = 16,
    parameter int CORDIC_STAGES = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // x_a[20:0], y_a[41:21], x_b[62:42], y_b[83:63], dist_in[103:84],
    // deg_in[112:104], min_in[118:113], sec_in[124:119], zero fill
    input  logic [pts_pkg::IN_DATA_W-1:0]      s_tdata,
    // mode[0]
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // x_out[37:0], y_out[75:38], dist_out[113:76], deg_out[122:114],
    // min_out[128:123], sec_out[134:129], zero fill
    output logic [pts_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import pts_pkg::*;

    // datapath width: widest start vector, guard fraction, CORDIC growth
    localparam int W = ((COORD_BITS + 1 > 20) ? COORD_BITS + 1 : 20)
                       + FRAC_BITS + GUARD_BITS + 3;
    localparam int N = CORDIC_STAGES;

    logic en;

    // coordinates: field zero-extended or cut to COORD_BITS, then signed
    logic [63:0] xa_t, ya_t, xb_t, yb_t;
    logic signed [COORD_BITS-1:0] xa_c, ya_c, xb_c, yb_c;

    always_comb
    begin
        xa_t = {43'd0, s_tdata[20:0]};
        ya_t = {43'd0, s_tdata[41:21]};
        xb_t = {43'd0, s_tdata[62:42]};
        yb_t = {43'd0, s_tdata[83:63]};
        xa_c = xa_t[COORD_BITS-1:0];
        ya_c = ya_t[COORD_BITS-1:0];
        xb_c = xb_t[COORD_BITS-1:0];
        yb_c = yb_t[COORD_BITS-1:0];
    end

    // chain links, index 0 is the front-end output
    ctl_t                         c_ctl [N+1];
    logic signed [W-1:0]          c_x   [N+1];
    logic signed [W-1:0]          c_y   [N+1];
    logic [31:0]                  c_z   [N+1];
    logic signed [COORD_BITS-1:0] c_xa  [N+1];
    logic signed [COORD_BITS-1:0] c_ya  [N+1];

    pts_prep #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .W         (W)
    ) u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_valid(s_tvalid),
        .mode    (s_tuser[0]),
        .x_a     (xa_c),
        .y_a     (ya_c),
        .x_b     (xb_c),
        .y_b     (yb_c),
        .dist_in (s_tdata[103:84]),
        .deg_in  (s_tdata[112:104]),
        .min_in  (s_tdata[118:113]),
        .sec_in  (s_tdata[124:119]),
        .ctl_out (c_ctl[0]),
        .x_out   (c_x[0]),
        .y_out   (c_y[0]),
        .z_out   (c_z[0]),
        .xa_out  (c_xa[0]),
        .ya_out  (c_ya[0])
    );

    // one cell per CORDIC iteration, each shifting by its own index
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        pts_cell #(
            .STAGE     (i),
            .W         (W),
            .COORD_BITS(COORD_BITS)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .ctl_in (c_ctl[i]),
            .x_in   (c_x[i]),
            .y_in   (c_y[i]),
            .z_in   (c_z[i]),
            .xa_in  (c_xa[i]),
            .ya_in  (c_ya[i]),
            .ctl_out(c_ctl[i+1]),
            .x_out  (c_x[i+1]),
            .y_out  (c_y[i+1]),
            .z_out  (c_z[i+1]),
            .xa_out (c_xa[i+1]),
            .ya_out (c_ya[i+1])
        );
    end

    logic                 p_valid;
    logic [OUT_W-1:0]     p_x, p_y, p_d;
    logic [8:0]           p_deg;
    logic [5:0]           p_min, p_sec;
    logic [OUT_DATA_W-1:0] p_data;

    pts_post #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .W         (W)
    ) u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (c_ctl[N]),
        .x_in    (c_x[N]),
        .y_in    (c_y[N]),
        .z_in    (c_z[N]),
        .xa_in   (c_xa[N]),
        .ya_in   (c_ya[N]),
        .valid   (p_valid),
        .x_out   (p_x),
        .y_out   (p_y),
        .dist_out(p_d),
        .deg_out (p_deg),
        .min_out (p_min),
        .sec_out (p_sec)
    );

    assign p_data = {1'b0, p_sec, p_min, p_deg, p_d, p_y, p_x};

    // output register plus skid entry
    logic                  out_v_reg, skid_v_reg;
    logic [OUT_DATA_W-1:0] out_d_reg, skid_d_reg;
    logic                  take;

    assign en       = !skid_v_reg;
    assign s_tready = en;
    assign take     = !out_v_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            if (take)
                out_v_reg <= skid_v_reg || p_valid;
            if (skid_v_reg && m_tready)
                skid_v_reg <= 1'b0;
            else if (!skid_v_reg && p_valid && !take)
                skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_d_reg <= skid_v_reg ? skid_d_reg : p_data;
        if (!skid_v_reg && p_valid && !take)
            skid_d_reg <= p_data;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

endmodule

// ===== sv/pts_prep.sv =====
// Front end: bearing to phase, gain-scaled distance, point differences.
// Three register stages feeding the CORDIC chain. Uses pts_pkg.
module pts_prep #(
    parameter int COORD_BITS = 21,
    parameter int FRAC_BITS  = 16,
    parameter int W          = 47
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] x_a,
    input  logic signed [COORD_BITS-1:0] y_a,
    input  logic signed [COORD_BITS-1:0] x_b,
    input  logic signed [COORD_BITS-1:0] y_b,
    input  logic [19:0]                  dist_in,
    input  logic [8:0]                   deg_in,
    input  logic [5:0]                   min_in,
    input  logic [5:0]                   sec_in,
    output pts_pkg::ctl_t                ctl_out,
    output logic signed [W-1:0]          x_out,
    output logic signed [W-1:0]          y_out,
    output logic [31:0]                  z_out,
    output logic signed [COORD_BITS-1:0] xa_out,
    output logic signed [COORD_BITS-1:0] ya_out
);
    import pts_pkg::*;

    localparam int F = FRAC_BITS + GUARD_BITS;
    // 2^32/1296000 = 3314 + 23296/1296000; the fraction reduces to (a*364+10125)/20250
    localparam logic [30:0] PH_REC = 31'(((64'd1 << 45) / 64'd20250) + 64'd1);

    // stage 1
    ctl_t                        ctl1_reg;
    logic [20:0]                 a1_reg;
    logic [51:0]                 dk1_reg;
    logic signed [COORD_BITS:0]  dx1_reg, dy1_reg;
    logic signed [COORD_BITS-1:0] xa1_reg, ya1_reg;
    logic [20:0]                 a_sum;

    // stage 2
    ctl_t                        ctl2_reg;
    logic [59:0]                 pr2_reg;
    logic [31:0]                 pa2_reg;
    logic [51:0]                 dk2_reg;
    logic signed [COORD_BITS:0]  dx2_reg, dy2_reg;
    logic signed [COORD_BITS-1:0] xa2_reg, ya2_reg;
    logic [28:0]                 n2;

    // stage 3
    ctl_t                        ctl3_reg;
    logic signed [W-1:0]         x3_reg, y3_reg;
    logic [31:0]                 z3_reg;
    logic signed [COORD_BITS-1:0] xa3_reg, ya3_reg;
    logic [31:0]                 p3, pm3;
    logic signed [W-1:0]         x0f, dxw, dyw;
    logic signed [W-1:0]         x_next, y_next;
    logic [31:0]                 z_next;

    always_comb
    begin
        a_sum = 21'(deg_in) * AS_DEG + 21'(min_in) * AS_MIN + 21'(sec_in);
        n2    = 29'(a1_reg) * 29'd364 + 29'd10125;
        p3    = pa2_reg + 32'(pr2_reg[59:45]);
        pm3   = p3 - QUARTER_TURN;
        x0f   = W'(dk2_reg >> (32 - F));
        dxw   = W'(dx2_reg) <<< F;
        dyw   = W'(dy2_reg) <<< F;
        if (ctl2_reg.inv)
        begin
            if (dx2_reg[COORD_BITS])
            begin
                x_next = -dxw;
                y_next = -dyw;
                z_next = HALF_TURN;
            end
            else
            begin
                x_next = dxw;
                y_next = dyw;
                z_next = '0;
            end
        end
        else
        begin
            y_next = '0;
            if (!pm3[31])
            begin
                x_next = -x0f;
                z_next = p3 - HALF_TURN;
            end
            else
            begin
                x_next = x0f;
                z_next = p3;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg.valid <= in_valid;
            ctl1_reg.inv   <= mode;
            ctl1_reg.zero  <= 1'b0;
            ctl2_reg.valid <= ctl1_reg.valid;
            ctl2_reg.inv   <= ctl1_reg.inv;
            ctl2_reg.zero  <= (dx1_reg == '0) && (dy1_reg == '0);
            ctl3_reg       <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg  <= (a_sum >= AS_TURN) ? a_sum - AS_TURN : a_sum;
            dk1_reg <= 52'(dist_in) * 52'(GAIN_Q32);
            dx1_reg <= (COORD_BITS+1)'(x_b) - (COORD_BITS+1)'(x_a);
            dy1_reg <= (COORD_BITS+1)'(y_b) - (COORD_BITS+1)'(y_a);
            xa1_reg <= x_a;
            ya1_reg <= y_a;

            pr2_reg <= 60'(n2) * 60'(PH_REC);
            pa2_reg <= 32'(a1_reg) * 32'd3314;
            dk2_reg <= dk1_reg;
            dx2_reg <= dx1_reg;
            dy2_reg <= dy1_reg;
            xa2_reg <= xa1_reg;
            ya2_reg <= ya1_reg;

            x3_reg  <= x_next;
            y3_reg  <= y_next;
            z3_reg  <= z_next;
            xa3_reg <= xa2_reg;
            ya3_reg <= ya2_reg;
        end
    end

    assign ctl_out = ctl3_reg;
    assign x_out   = x3_reg;
    assign y_out   = y3_reg;
    assign z_out   = z3_reg;
    assign xa_out  = xa3_reg;
    assign ya_out  = ya3_reg;

endmodule

// ===== sv/pts_cell.sv =====
// One CORDIC iteration cell, rotation or vectoring per item.
// Uses pts_pkg for the control struct and the arctangent table.
module pts_cell #(
    parameter int STAGE      = 0,
    parameter int W          = 47,
    parameter int COORD_BITS = 21
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  pts_pkg::ctl_t                ctl_in,
    input  logic signed [W-1:0]          x_in,
    input  logic signed [W-1:0]          y_in,
    input  logic [31:0]                  z_in,
    input  logic signed [COORD_BITS-1:0] xa_in,
    input  logic signed [COORD_BITS-1:0] ya_in,
    output pts_pkg::ctl_t                ctl_out,
    output logic signed [W-1:0]          x_out,
    output logic signed [W-1:0]          y_out,
    output logic [31:0]                  z_out,
    output logic signed [COORD_BITS-1:0] xa_out,
    output logic signed [COORD_BITS-1:0] ya_out
);
    import pts_pkg::*;

    localparam logic [31:0] ANGLE = atan_phase(STAGE);

    ctl_t                         ctl_reg;
    logic signed [W-1:0]          x_reg, y_reg;
    logic [31:0]                  z_reg;
    logic signed [COORD_BITS-1:0] xa_reg, ya_reg;
    logic signed [W-1:0]          xs, ys;
    logic                         up;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        // vectoring: y >= 0; rotation: z < 0
        up = ctl_in.inv ? ~y_in[W-1] : z_in[31];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (up)
            begin
                x_reg <= x_in + ys;
                y_reg <= y_in - xs;
                z_reg <= z_in + ANGLE;
            end
            else
            begin
                x_reg <= x_in - ys;
                y_reg <= y_in + xs;
                z_reg <= z_in - ANGLE;
            end
            xa_reg <= xa_in;
            ya_reg <= ya_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign xa_out  = xa_reg;
    assign ya_out  = ya_reg;

endmodule

// ===== sv/pts_post.sv =====
// Back end: rounding, saturation, gain correction, phase to deg/min/sec.
// Three register stages after the CORDIC chain. Uses pts_pkg.
module pts_post #(
    parameter int COORD_BITS = 21,
    parameter int FRAC_BITS  = 16,
    parameter int W          = 47
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  pts_pkg::ctl_t                ctl_in,
    input  logic signed [W-1:0]          x_in,
    input  logic signed [W-1:0]          y_in,
    input  logic [31:0]                  z_in,
    input  logic signed [COORD_BITS-1:0] xa_in,
    input  logic signed [COORD_BITS-1:0] ya_in,
    output logic                         valid,
    output logic [pts_pkg::OUT_W-1:0]    x_out,
    output logic [pts_pkg::OUT_W-1:0]    y_out,
    output logic [pts_pkg::OUT_W-1:0]    dist_out,
    output logic [8:0]                   deg_out,
    output logic [5:0]                   min_out,
    output logic [5:0]                   sec_out
);
    import pts_pkg::*;

    localparam int SW = W + 2;
    localparam int EW = ((SW > OUT_W) ? SW : OUT_W) + 1;
    localparam logic signed [EW-1:0] SMAX = {{(EW-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN = ~SMAX;
    localparam logic [22:0] DEG_REC = 23'(((64'd1 << 34) / 64'd3600) + 64'd1);
    localparam logic [14:0] MIN_REC = 15'(((64'd1 << 20) / 64'd60) + 64'd1);

    // stage 1
    ctl_t              ctl1_reg;
    logic [OUT_W-1:0]  xo1_reg, yo1_reg;
    logic [W-1:0]      ph1_reg;
    logic [31:0]       pl1_reg;
    logic [20:0]       as1_reg;
    logic signed [W-1:0]  xr, yr;
    logic signed [SW-1:0] sx, sy;
    logic signed [EW-1:0] ex, ey;
    logic [W-1:0]      xc;
    logic [63:0]       pl_full;
    logic [52:0]       as_full;

    // stage 2
    ctl_t              ctl2_reg;
    logic [OUT_W-1:0]  xo2_reg, yo2_reg, do2_reg;
    logic [20:0]       as2_reg;
    logic [8:0]        dg2_reg;
    logic [W:0]        m2;
    logic [W:0]        r2;
    logic [20:0]       asw;
    logic [43:0]       dq;

    // stage 3
    ctl_t              ctl3_reg;
    logic [OUT_W-1:0]  xo3_reg, yo3_reg, do3_reg;
    logic [8:0]        dg3_reg;
    logic [5:0]        mn3_reg, sc3_reg;
    logic [11:0]       rem;
    logic [26:0]       mq;
    logic [5:0]        mn;
    logic [11:0]       sc;

    always_comb
    begin
        xr = (x_in + W'(8)) >>> GUARD_BITS;
        yr = (y_in + W'(8)) >>> GUARD_BITS;
        sx = SW'(xr) + (SW'(xa_in) <<< FRAC_BITS);
        sy = SW'(yr) + (SW'(ya_in) <<< FRAC_BITS);
        ex = EW'(sx);
        ey = EW'(sy);
        xc = x_in[W-1] ? '0 : x_in;
        pl_full = 64'(xc[31:0]) * 64'(GAIN_Q32);
        as_full = 53'(z_in) * 53'(AS_TURN) + 53'(HALF_TURN);

        m2  = (W+1)'(ph1_reg) + (W+1)'(pl1_reg);
        r2  = (m2 + (W+1)'(8)) >> GUARD_BITS;
        asw = (as1_reg >= AS_TURN) ? '0 : as1_reg;
        dq  = 44'(asw) * 44'(DEG_REC);

        rem = 12'(as2_reg - 21'(dg2_reg) * AS_DEG);
        mq  = 27'(rem) * 27'(MIN_REC);
        mn  = mq[25:20];
        sc  = rem - 12'(mn) * 12'(AS_MIN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ex > SMAX)
                xo1_reg <= SMAX[OUT_W-1:0];
            else if (ex < SMIN)
                xo1_reg <= SMIN[OUT_W-1:0];
            else
                xo1_reg <= ex[OUT_W-1:0];
            if (ey > SMAX)
                yo1_reg <= SMAX[OUT_W-1:0];
            else if (ey < SMIN)
                yo1_reg <= SMIN[OUT_W-1:0];
            else
                yo1_reg <= ey[OUT_W-1:0];
            // floor(x*K) split at bit 32 into two narrow products
            ph1_reg <= W'(xc[W-1:32]) * W'(GAIN_Q32);
            pl1_reg <= pl_full[63:32];
            as1_reg <= as_full[52:32];

            xo2_reg <= xo1_reg;
            yo2_reg <= yo1_reg;
            do2_reg <= (r2 > (W+1)'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : r2[OUT_W-1:0];
            as2_reg <= asw;
            dg2_reg <= dq[42:34];

            xo3_reg <= xo2_reg;
            yo3_reg <= yo2_reg;
            do3_reg <= do2_reg;
            dg3_reg <= dg2_reg;
            mn3_reg <= mn;
            sc3_reg <= sc[5:0];
        end
    end

    // unused fields of each mode, and coincident points, read as zero
    always_comb
    begin
        valid    = ctl3_reg.valid;
        x_out    = ctl3_reg.inv ? '0 : xo3_reg;
        y_out    = ctl3_reg.inv ? '0 : yo3_reg;
        dist_out = (ctl3_reg.inv && !ctl3_reg.zero) ? do3_reg : '0;
        deg_out  = (ctl3_reg.inv && !ctl3_reg.zero) ? dg3_reg : '0;
        min_out  = (ctl3_reg.inv && !ctl3_reg.zero) ? mn3_reg : '0;
        sec_out  = (ctl3_reg.inv && !ctl3_reg.zero) ? sc3_reg : '0;
    end

endmodule
